/* design/plic_pkg.sv */
package plic_pkg;

    localparam int SOURCES_DEF   = 64;
    localparam int PRIO_BITS_DEF = 3;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 22;
    localparam int DATA_W     = 32;
    localparam int SRC_PORT_W = 6;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_RAISE = 2'd2;

    localparam logic [ADDR_W-1:0] PENDING_BASE   = 22'h001000;
    localparam logic [ADDR_W-1:0] ENABLE_BASE    = 22'h002000;
    localparam logic [ADDR_W-1:0] CONTEXT_STRIDE = 22'h000080;
    localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = 22'h200000;
    localparam logic [ADDR_W-1:0] CLAIM_ADDR     = 22'h200004;

    typedef logic [3:0] t_kind;

    localparam t_kind K_NONE     = 4'd0;
    localparam t_kind K_PRIO_RD  = 4'd1;
    localparam t_kind K_PRIO_WR  = 4'd2;
    localparam t_kind K_PEND_RD  = 4'd3;
    localparam t_kind K_EN_RD    = 4'd4;
    localparam t_kind K_EN_WR    = 4'd5;
    localparam t_kind K_THR_RD   = 4'd6;
    localparam t_kind K_THR_WR   = 4'd7;
    localparam t_kind K_CLAIM    = 4'd8;
    localparam t_kind K_COMPLETE = 4'd9;
    localparam t_kind K_RAISE    = 4'd10;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] bit_pos;
    } t_req;

endpackage

/* design/plic_decode.sv */
module plic_decode
    import plic_pkg::*;
#(
    parameter int SOURCES = SOURCES_DEF
) (
    input  logic [OP_W-1:0]       i_operation,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [DATA_W-1:0]     i_write_data,
    input  logic [SRC_PORT_W-1:0] i_source,
    output t_req                  o_req,
    output logic [$clog2(SOURCES)-1:0] o_src_idx,
    output logic [((SOURCES+31)/32 > 1 ? $clog2((SOURCES+31)/32) : 1)-1:0] o_word_idx
);

    localparam int SRC_W   = $clog2(SOURCES);
    localparam int WORDS   = (SOURCES + 31) / 32;
    localparam int WORD_AW = WORDS > 1 ? $clog2(WORDS) : 1;

    localparam logic [ADDR_W-1:0] PRIO_END = ADDR_W'(4 * SOURCES);
    localparam logic [ADDR_W-1:0] PEND_END = PENDING_BASE + ADDR_W'(4 * WORDS);
    localparam logic [ADDR_W-1:0] EN_END   = ENABLE_BASE + CONTEXT_STRIDE;

    logic [ADDR_W-1:0] a;
    logic              in_prio;
    logic              prio_nz;
    logic              in_pend;
    logic              in_en;
    logic              cpl_ok;
    logic              src_ok;
    logic              word_from_addr;
    logic [SRC_W-1:0]  src_idx;
    t_kind             req_kind;

    assign a       = {i_address[ADDR_W-1:2], 2'b00};
    assign in_prio = a < PRIO_END;
    assign prio_nz = a[SRC_W+1:2] != '0;
    assign in_pend = a inside {[PENDING_BASE:PEND_END-1]};
    // enable block is 32 words wide, only the first WORDS are backed
    assign in_en   = (a inside {[ENABLE_BASE:EN_END-1]}) && (32'(a[6:2]) < 32'(WORDS));
    assign cpl_ok  = (i_write_data != '0) && (i_write_data < 32'(SOURCES));
    assign src_ok  = (i_source != '0) && (32'(i_source) < 32'(SOURCES));

    always_comb begin
        req_kind = K_NONE;
        src_idx  = a[SRC_W+1:2];
        case (i_operation)
            OP_READ: begin
                if (in_prio) begin
                    if (prio_nz) req_kind = K_PRIO_RD;
                end else if (in_pend) begin
                    req_kind = K_PEND_RD;
                end else if (in_en) begin
                    req_kind = K_EN_RD;
                end else if (a == THRESHOLD_ADDR) begin
                    req_kind = K_THR_RD;
                end else if (a == CLAIM_ADDR) begin
                    req_kind = K_CLAIM;
                end
            end
            OP_WRITE: begin
                if (in_prio) begin
                    if (prio_nz) req_kind = K_PRIO_WR;
                end else if (in_en) begin
                    req_kind = K_EN_WR;
                end else if (a == THRESHOLD_ADDR) begin
                    req_kind = K_THR_WR;
                end else if (a == CLAIM_ADDR && cpl_ok) begin
                    req_kind = K_COMPLETE;
                    src_idx  = SRC_W'(i_write_data);
                end
            end
            OP_RAISE: begin
                if (src_ok) begin
                    req_kind = K_RAISE;
                    src_idx  = SRC_W'(i_source);
                end
            end
            default: req_kind = K_NONE;
        endcase
    end

    assign word_from_addr = (req_kind == K_PEND_RD) || (req_kind == K_EN_RD) ||
                            (req_kind == K_EN_WR);

    assign o_src_idx  = src_idx;
    assign o_word_idx = word_from_addr ? WORD_AW'(a[6:2]) : WORD_AW'(src_idx >> 5);
    assign o_req      = '{kind: req_kind, bit_pos: 5'(src_idx)};

endmodule

/* design/plic_scan.sv */
module plic_scan
    import plic_pkg::*;
#(
    parameter int SOURCES   = SOURCES_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_init,
    input  logic [PRIO_BITS-1:0]       i_thr,
    input  logic                       i_cmp,
    input  logic                       i_hit,
    input  logic [$clog2(SOURCES)-1:0] i_idx,
    input  logic [PRIO_BITS-1:0]       i_prio,
    output logic [$clog2(SOURCES)-1:0] o_best
);

    logic [$clog2(SOURCES)-1:0] r_best;
    logic [PRIO_BITS-1:0]       r_best_prio;

    // strict compare keeps the lowest id on ties, since ids arrive ascending
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_best      <= '0;
            r_best_prio <= i_thr;
        end else if (i_cmp && i_hit && (i_prio > r_best_prio)) begin
            r_best      <= i_idx;
            r_best_prio <= i_prio;
        end
    end

    assign o_best = r_best;

endmodule

/* design/platform_interrupt_controller_core.sv */
// Flow: a request is read from the RAMs in S_RD, written back in S_WR, then a
// priority scan runs; a claim that finds a source runs the scan twice.
// One request is handled at a time, as o_ready is high only in S_IDLE; the
// scan reads one source per cycle through the priority RAM port.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the RAMs,
// with o_ready low until it ends.
module platform_interrupt_controller_core
    import plic_pkg::*;
#(
    parameter int SOURCES   = SOURCES_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [DATA_W-1:0]     i_write_data,
    input  logic [SRC_PORT_W-1:0] i_source,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_W-1:0]     o_read_data,
    output logic                  o_interrupt_request
);

    localparam int SRC_W   = $clog2(SOURCES);
    localparam int WORDS   = (SOURCES + 31) / 32;
    localparam int WORD_AW = WORDS > 1 ? $clog2(WORDS) : 1;

    localparam logic [SRC_W-1:0] LAST = SRC_W'(SOURCES - 1);
    localparam logic [SRC_W-1:0] FIRST = SRC_W'(1);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_RD       = 3'd2;
    localparam logic [2:0] S_WR       = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_CLAIM_RD = 3'd5;
    localparam logic [2:0] S_CLAIM_WR = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    function automatic logic [WORD_AW-1:0] word_of(input logic [SRC_W-1:0] idx);
        return WORD_AW'(idx >> 5);
    endfunction

    // storage
    logic [PRIO_BITS-1:0] prio_mem  [SOURCES];
    logic [31:0]          pend_mem  [WORDS];
    logic [31:0]          en_mem    [WORDS];
    logic [31:0]          insvc_mem [WORDS];

    logic [PRIO_BITS-1:0] r_prio_q;
    logic [31:0]          r_pend_q;
    logic [31:0]          r_en_q;
    logic [31:0]          r_insvc_q;

    // sequencer
    logic [2:0]           r_state;
    logic [SRC_W-1:0]     r_idx;
    logic                 r_issue;
    logic                 r_cmp_v;
    logic [SRC_W-1:0]     r_cmp_idx;
    logic                 r_claim;
    logic [PRIO_BITS-1:0] r_thr;
    logic [PRIO_BITS-1:0] n_thr;

    t_req                 r_req;
    logic [SRC_W-1:0]     r_src_idx;
    logic [WORD_AW-1:0]   r_word_idx;
    logic [DATA_W-1:0]    r_data;
    logic [DATA_W-1:0]    r_rd;
    logic                 r_irq;

    logic                 r_o_valid;
    logic [DATA_W-1:0]    r_o_read_data;
    logic                 r_o_irq;

    t_req                 dec_req;
    logic [SRC_W-1:0]     dec_src_idx;
    logic [WORD_AW-1:0]   dec_word_idx;

    logic [SRC_W-1:0]     best;
    logic                 scan_init;
    logic                 scan_hit;
    logic [4:0]           cmp_bit;

    logic [SRC_W-1:0]     prio_raddr;
    logic [WORD_AW-1:0]   word_raddr;
    logic                 prio_we;
    logic [SRC_W-1:0]     prio_waddr;
    logic [PRIO_BITS-1:0] prio_wdata;
    logic                 clr_row;
    logic [WORD_AW-1:0]   word_waddr;
    logic                 pend_we;
    logic [31:0]          pend_wdata;
    logic                 en_we;
    logic [31:0]          en_wdata;
    logic                 insvc_we;
    logic [31:0]          insvc_wdata;
    logic [31:0]          req_oh;
    logic [31:0]          best_oh;
    logic [31:0]          en_mask;
    logic                 accept;

    plic_decode #(
        .SOURCES(SOURCES)
    ) u_decode (
        .i_operation (i_operation),
        .i_address   (i_address),
        .i_write_data(i_write_data),
        .i_source    (i_source),
        .o_req       (dec_req),
        .o_src_idx   (dec_src_idx),
        .o_word_idx  (dec_word_idx)
    );

    assign cmp_bit  = 5'(r_cmp_idx);
    assign scan_hit = r_pend_q[cmp_bit] & r_en_q[cmp_bit];
    assign scan_init = (r_state == S_WR) || (r_state == S_CLAIM_WR);
    assign n_thr = (r_state == S_WR && r_req.kind == K_THR_WR) ?
                   r_data[PRIO_BITS-1:0] : r_thr;

    plic_scan #(
        .SOURCES  (SOURCES),
        .PRIO_BITS(PRIO_BITS)
    ) u_scan (
        .i_clk (i_clk),
        .i_init(scan_init),
        .i_thr (n_thr),
        .i_cmp (r_cmp_v),
        .i_hit (scan_hit),
        .i_idx (r_cmp_idx),
        .i_prio(r_prio_q),
        .o_best(best)
    );

    assign accept  = i_valid && (r_state == S_IDLE);
    assign req_oh  = 32'd1 << r_req.bit_pos;
    assign best_oh = 32'd1 << 5'(best);

    // source zero and ids from SOURCES up never get an enable bit
    always_comb begin
        for (int b = 0; b < 32; b++) begin
            en_mask[b] = ({r_word_idx, 5'(b)} != '0) &&
                         (32'({r_word_idx, 5'(b)}) < 32'(SOURCES));
        end
    end

    always_comb begin
        prio_raddr = (r_state == S_SCAN) ? r_idx : r_src_idx;
        if (r_state == S_SCAN) begin
            word_raddr = word_of(r_idx);
        end else if (r_state == S_CLAIM_RD) begin
            word_raddr = word_of(best);
        end else begin
            word_raddr = r_word_idx;
        end
    end

    always_comb begin
        clr_row     = (r_state == S_CLEAR) && (32'(r_idx) < 32'(WORDS));
        prio_we     = (r_state == S_CLEAR) || (r_state == S_WR && r_req.kind == K_PRIO_WR);
        prio_waddr  = (r_state == S_CLEAR) ? r_idx : r_src_idx;
        prio_wdata  = (r_state == S_CLEAR) ? '0 : r_data[PRIO_BITS-1:0];
        word_waddr  = r_word_idx;
        pend_we     = 1'b0;
        pend_wdata  = '0;
        en_we       = 1'b0;
        en_wdata    = '0;
        insvc_we    = 1'b0;
        insvc_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                word_waddr = WORD_AW'(r_idx);
                pend_we    = clr_row;
                en_we      = clr_row;
                insvc_we   = clr_row;
            end
            S_WR: begin
                case (r_req.kind)
                    K_RAISE: begin
                        // gateway holds a source that is in service
                        pend_we    = !r_insvc_q[r_req.bit_pos];
                        pend_wdata = r_pend_q | req_oh;
                    end
                    K_EN_WR: begin
                        en_we    = 1'b1;
                        en_wdata = r_data & en_mask;
                    end
                    K_COMPLETE: begin
                        insvc_we    = 1'b1;
                        insvc_wdata = r_insvc_q & ~req_oh;
                    end
                    default: pend_we = 1'b0;
                endcase
            end
            S_CLAIM_WR: begin
                word_waddr  = word_of(best);
                pend_we     = 1'b1;
                pend_wdata  = r_pend_q & ~best_oh;
                insvc_we    = 1'b1;
                insvc_wdata = r_insvc_q | best_oh;
            end
            default: pend_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (prio_we) prio_mem[prio_waddr] <= prio_wdata;
        if (pend_we) pend_mem[word_waddr] <= pend_wdata;
        if (en_we) en_mem[word_waddr] <= en_wdata;
        if (insvc_we) insvc_mem[word_waddr] <= insvc_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_prio_q  <= prio_mem[prio_raddr];
        r_pend_q  <= pend_mem[word_raddr];
        r_en_q    <= en_mem[word_raddr];
        r_insvc_q <= insvc_mem[word_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_issue   <= 1'b0;
            r_cmp_v   <= 1'b0;
            r_claim   <= 1'b0;
            r_thr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && (r_state != S_DONE)) r_o_valid <= 1'b0;
            r_thr <= n_thr;
            case (r_state)
                S_CLEAR: begin
                    if (r_idx == LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_req      <= dec_req;
                        r_src_idx  <= dec_src_idx;
                        r_word_idx <= dec_word_idx;
                        r_data     <= i_write_data;
                        r_state    <= S_RD;
                    end
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    case (r_req.kind)
                        K_PRIO_RD: r_rd <= DATA_W'(r_prio_q);
                        K_PEND_RD: r_rd <= r_pend_q;
                        K_EN_RD:   r_rd <= r_en_q;
                        K_THR_RD:  r_rd <= DATA_W'(r_thr);
                        default:   r_rd <= '0;
                    endcase
                    r_claim <= (r_req.kind == K_CLAIM);
                    r_idx   <= FIRST;
                    r_issue <= 1'b1;
                    r_cmp_v <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_cmp_v   <= r_issue;
                    r_cmp_idx <= r_idx;
                    if (r_issue) begin
                        if (r_idx == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else if (!r_cmp_v) begin
                        // last compare has landed in the scan unit
                        if (r_claim && best != '0) begin
                            r_rd    <= DATA_W'(best);
                            r_claim <= 1'b0;
                            r_state <= S_CLAIM_RD;
                        end else begin
                            r_irq   <= best != '0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CLAIM_RD: r_state <= S_CLAIM_WR;
                S_CLAIM_WR: begin
                    r_idx   <= FIRST;
                    r_issue <= 1'b1;
                    r_cmp_v <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_DONE: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid     <= 1'b1;
                        r_o_read_data <= r_rd;
                        r_o_irq       <= r_irq;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready             = (r_state == S_IDLE);
    assign o_valid             = r_o_valid;
    assign o_read_data         = r_o_read_data;
    assign o_interrupt_request = r_o_irq;

endmodule

/* design/plic_checker.sv */
module plic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_read_data,
    input logic        o_interrupt_request
);

    logic [1:0] r_cnt;

    // requests accepted whose result has not been taken yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("outputs active right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data) &&
                                $stable(o_interrupt_request))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready again right after a request");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != 2'd0)
        else $error("result without a request");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_cnt <= 2'd1)
        else $error("ready with two requests outstanding");

endmodule

bind platform_interrupt_controller_core plic_checker u_plic_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import plic_pkg::*;

    localparam int NSRC    = SOURCES_DEF;
    localparam int PBITS   = PRIO_BITS_DEF;
    localparam int WORDS   = (NSRC + 31) / 32;
    localparam int SEGS    = 5;
    localparam int PER_SEG = 285;
    localparam int HOLD_CYCLES = 400;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_W-1:0]     data;
        logic [SRC_PORT_W-1:0] src;
    } t_bus_req;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              irq;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [OP_W-1:0]       i_operation = '0;
    logic [ADDR_W-1:0]     i_address = '0;
    logic [DATA_W-1:0]     i_write_data = '0;
    logic [SRC_PORT_W-1:0] i_source = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [DATA_W-1:0]     o_read_data;
    logic                  o_interrupt_request;

    platform_interrupt_controller_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_operation         (i_operation),
        .i_address           (i_address),
        .i_write_data        (i_write_data),
        .i_source            (i_source),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_read_data         (o_read_data),
        .o_interrupt_request (o_interrupt_request)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the controller state
    logic [PBITS-1:0] src_prio [NSRC];
    logic [NSRC-1:0]  src_pend = '0;
    logic [NSRC-1:0]  src_en = '0;
    logic [NSRC-1:0]  src_act = '0;
    logic [PBITS-1:0] thr_lvl = '0;

    t_bus_req req_q [$];
    t_result  result_q [$];
    t_bus_req cur_req;
    t_result  want;

    int queued_n = 0;
    int sent_n = 0;
    int checked_n = 0;
    int fail_n = 0;
    int grants_n = 0;
    int latched_n = 0;
    int send_pct = 0;
    int recv_pct = 0;
    int hold_left = 0;
    logic hold_go = 1'b0;

    initial begin
        for (int n = 0; n < NSRC; n++) src_prio[n] = '0;
    end

    function automatic logic coin(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // highest priority above threshold, lowest id on ties
    function automatic logic [SRC_PORT_W-1:0] top_eligible();
        logic [SRC_PORT_W-1:0] pick;
        logic [PBITS-1:0]      lvl;
        pick = '0;
        lvl = thr_lvl;
        for (int n = 1; n < NSRC; n++) begin
            if (src_pend[n] && src_en[n] && src_prio[n] > lvl) begin
                pick = SRC_PORT_W'(n);
                lvl = src_prio[n];
            end
        end
        return pick;
    endfunction

    function automatic t_result predict_request(t_bus_req r);
        t_result               res;
        logic [ADDR_W-1:0]     a;
        int                    w;
        logic [SRC_PORT_W-1:0] win;
        res = '0;
        a = {r.addr[ADDR_W-1:2], 2'b00};
        case (r.op)
            OP_READ: begin
                if (a < 4 * NSRC) begin
                    res.rdata = DATA_W'(src_prio[a[7:2]]);
                end else if (a >= PENDING_BASE && a < PENDING_BASE + 4 * WORDS) begin
                    w = int'((a - PENDING_BASE) >> 2);
                    res.rdata = src_pend[w*32 +: 32];
                end else if (a >= ENABLE_BASE && a < ENABLE_BASE + CONTEXT_STRIDE) begin
                    w = int'((a - ENABLE_BASE) >> 2);
                    if (w < WORDS) res.rdata = src_en[w*32 +: 32];
                end else if (a == THRESHOLD_ADDR) begin
                    res.rdata = DATA_W'(thr_lvl);
                end else if (a == CLAIM_ADDR) begin
                    win = top_eligible();
                    if (win != 0) begin
                        src_pend[win] = 1'b0;
                        src_act[win] = 1'b1;
                        grants_n++;
                    end
                    res.rdata = DATA_W'(win);
                end
            end
            OP_WRITE: begin
                if (a < 4 * NSRC) begin
                    if (a[7:2] != 0) src_prio[a[7:2]] = r.data[PBITS-1:0];
                end else if (a >= ENABLE_BASE && a < ENABLE_BASE + CONTEXT_STRIDE) begin
                    w = int'((a - ENABLE_BASE) >> 2);
                    if (w < WORDS) begin
                        src_en[w*32 +: 32] = r.data;
                        src_en[0] = 1'b0;
                    end
                end else if (a == THRESHOLD_ADDR) begin
                    thr_lvl = r.data[PBITS-1:0];
                end else if (a == CLAIM_ADDR) begin
                    if (r.data != 0 && r.data < NSRC) src_act[r.data[SRC_PORT_W-1:0]] = 1'b0;
                end
            end
            OP_RAISE: begin
                // gateway blocks a source until its service completes
                if (r.src != 0 && !src_act[r.src] && !src_pend[r.src]) begin
                    src_pend[r.src] = 1'b1;
                    latched_n++;
                end
            end
            default: begin
            end
        endcase
        res.irq = (top_eligible() != 0);
        return res;
    endfunction

    task automatic queue_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                 logic [DATA_W-1:0] data, logic [SRC_PORT_W-1:0] src);
        t_bus_req r;
        r.op = op;
        r.addr = addr;
        r.data = data;
        r.src = src;
        req_q.push_back(r);
        queued_n++;
    endtask

    task automatic queue_random_request();
        int                    pick;
        int                    w;
        int                    busy [$];
        logic [ADDR_W-1:0]     a;
        logic [DATA_W-1:0]     d;
        logic [SRC_PORT_W-1:0] s;
        pick = $urandom_range(0, 99);
        a = ADDR_W'($urandom);
        d = $urandom;
        s = SRC_PORT_W'($urandom);
        if (pick < 24) begin
            if ($urandom_range(0, 19) != 0) s = SRC_PORT_W'($urandom_range(1, NSRC - 1));
            queue_request(OP_RAISE, a, d, s);
        end else if (pick < 38) begin
            queue_request(OP_READ, CLAIM_ADDR | ADDR_W'($urandom_range(0, 3)), d, s);
        end else if (pick < 50) begin
            for (int n = 1; n < NSRC; n++) if (src_act[n]) busy.push_back(n);
            if (busy.size() != 0 && $urandom_range(0, 7) != 0)
                d = DATA_W'(busy[$urandom_range(0, busy.size() - 1)]);
            else if ($urandom_range(0, 1) == 0)
                d = DATA_W'($urandom_range(0, NSRC - 1));
            queue_request(OP_WRITE, CLAIM_ADDR | ADDR_W'($urandom_range(0, 3)), d, s);
        end else if (pick < 60) begin
            a = ADDR_W'($urandom_range(0, 4 * NSRC - 1));
            queue_request(OP_WRITE, a, d, s);
        end else if (pick < 67) begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(WORDS, 31) : $urandom_range(0, WORDS - 1);
            case ($urandom_range(0, 3))
                0: d = '1;
                1: d = $urandom & $urandom;
                default: begin
                end
            endcase
            queue_request(OP_WRITE, ENABLE_BASE + ADDR_W'(4 * w + $urandom_range(0, 3)), d, s);
        end else if (pick < 71) begin
            // keep the threshold low most of the time so claims can succeed
            if ($urandom_range(0, 3) != 0) d = DATA_W'($urandom_range(0, 2));
            queue_request(OP_WRITE, THRESHOLD_ADDR | ADDR_W'($urandom_range(0, 3)), d, s);
        end else if (pick < 91) begin
            case ($urandom_range(0, 3))
                0: a = ADDR_W'($urandom_range(0, 4 * NSRC - 1));
                1: a = PENDING_BASE + ADDR_W'($urandom_range(0, 15));
                2: a = ENABLE_BASE + ADDR_W'($urandom_range(0, 127));
                default: a = THRESHOLD_ADDR | ADDR_W'($urandom_range(0, 3));
            endcase
            queue_request(OP_READ, a, d, s);
        end else begin
            queue_request(OP_UNUSED - OP_W'($urandom_range(0, 3)), a, d, s);
        end
    endtask

    task automatic wait_all_done();
        while (sent_n != queued_n || result_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                result_q.push_back(predict_request(cur_req));
                sent_n++;
            end
            if (!i_valid || o_ready) begin
                if (req_q.size() != 0 && !coin(send_pct)) begin
                    cur_req = req_q.pop_front();
                    i_operation <= cur_req.op;
                    i_address <= cur_req.addr;
                    i_write_data <= cur_req.data;
                    i_source <= cur_req.src;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_go) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("unexpected result: read_data %h irq %b",
                                 o_read_data, o_interrupt_request);
                end else begin
                    want = result_q.pop_front();
                    checked_n++;
                    if (o_read_data !== want.rdata || o_interrupt_request !== want.irq) begin
                        fail_n++;
                        if (fail_n <= 10)
                            $display("mismatch on result %0d: read_data exp %h got %h, irq exp %b got %b",
                                     checked_n, want.rdata, o_read_data, want.irq,
                                     o_interrupt_request);
                    end
                end
            end
            i_ready <= (hold_left == 0) && !coin(recv_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening: empty claim, masking, ignored writes, tie break,
        // gateway blocking, threshold extremes, completes, unmapped and op 3
        queue_request(OP_READ, CLAIM_ADDR, '0, '0);
        queue_request(OP_READ, PENDING_BASE, '0, '0);
        queue_request(OP_WRITE, 22'h000000, 32'hFFFF_FFFF, '0);
        queue_request(OP_WRITE, 22'h000004, 32'hFFFF_FFFF, '0);
        queue_request(OP_WRITE, 22'h0000FF, 32'h0000_0005, '0);
        queue_request(OP_WRITE, 22'h000008, 32'h0000_0007, '0);
        queue_request(OP_WRITE, ENABLE_BASE, 32'hFFFF_FFFF, '0);
        queue_request(OP_WRITE, ENABLE_BASE + 22'd4, 32'hFFFF_FFFF, '0);
        queue_request(OP_WRITE, ENABLE_BASE + 22'd8, 32'hFFFF_FFFF, '0);
        queue_request(OP_READ, ENABLE_BASE + 22'd8, '0, '0);
        queue_request(OP_WRITE, PENDING_BASE, 32'hFFFF_FFFF, '0);
        queue_request(OP_RAISE, '0, '0, 6'd0);
        queue_request(OP_RAISE, '0, '0, 6'd63);
        queue_request(OP_RAISE, '1, '1, 6'd1);
        queue_request(OP_RAISE, '0, '0, 6'd2);
        queue_request(OP_READ, PENDING_BASE + 22'd4, '0, '0);
        queue_request(OP_READ, CLAIM_ADDR, '0, '0);
        queue_request(OP_RAISE, '0, '0, 6'd1);
        queue_request(OP_WRITE, THRESHOLD_ADDR, 32'hFFFF_FFFF, '0);
        queue_request(OP_READ, THRESHOLD_ADDR | 22'd3, '0, '0);
        queue_request(OP_WRITE, THRESHOLD_ADDR, '0, '0);
        queue_request(OP_WRITE, CLAIM_ADDR, '0, '0);
        queue_request(OP_WRITE, CLAIM_ADDR, 32'd1, '0);
        queue_request(OP_WRITE, CLAIM_ADDR, 32'd1, '0);
        queue_request(OP_UNUSED, '1, '1, '1);
        queue_request(OP_READ, '1, '0, '0);
        queue_request(OP_WRITE, 22'h3FFFFC, 32'hA5A5_5A5A, '0);
        queue_request(OP_READ, 22'h000000, '0, '0);
        wait_all_done();

        for (int seg = 0; seg < SEGS; seg++) begin
            @(posedge i_clk);
            case (seg)
                1: begin send_pct <= 86; recv_pct <= 0; end
                2: begin send_pct <= 0; recv_pct <= 86; end
                3: begin send_pct <= 35; recv_pct <= 35; end
                default: begin send_pct <= 0; recv_pct <= 0; end
            endcase
            if (seg == 0) begin
                // receiver blocks for a long stretch while requests keep coming
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            for (int k = 0; k < PER_SEG; k++) begin
                while (queued_n - sent_n > 3) @(posedge i_clk);
                queue_random_request();
            end
            wait_all_done();
        end

        repeat (2 * NSRC + 20) @(posedge i_clk);
        $display("covered %0d requests in free, sender-idle, receiver-stall and mixed phases",
                 sent_n);
        $display("%0d results checked, %0d claims granted, %0d raises latched, %0d mismatches",
                 checked_n, grants_n, latched_n, fail_n);
        if (fail_n == 0 && result_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

/* files.f */
design/plic_pkg.sv
design/plic_decode.sv
design/plic_scan.sv
design/platform_interrupt_controller_core.sv
design/plic_checker.sv
dv/tb.sv
